// ===== design/bvt_pkg.sv =====
// ---------------------------------------------------------------------------
// bvt_pkg: shared types and constants for the bounding volume transform
// Q16.16 fixed point formats, transaction structs, shape and register codes.
// ---------------------------------------------------------------------------
`default_nettype none

package bvt_pkg;

  localparam int unsigned FracBits = 16;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // shape codes
  localparam logic [1:0] ShapeNone   = 2'd0;
  localparam logic [1:0] ShapeSphere = 2'd1;
  localparam logic [1:0] ShapeBox    = 2'd2;

  // matrix column carrying the translation
  localparam logic [1:0] ColTranslate = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgShapeMode = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCenterX   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCenterY   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgCenterZ   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRadius    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgHalfX     = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgHalfY     = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgHalfZ     = 3'd7;

  typedef struct packed {
    logic        [1:0]  column;
    logic signed [31:0] elem_x;
    logic signed [31:0] elem_y;
    logic signed [31:0] elem_z;
    logic        [30:0] scale_x;
    logic        [30:0] scale_y;
    logic        [30:0] scale_z;
  } in_t;

  typedef struct packed {
    logic        [1:0]  shape;
    logic signed [31:0] low_x;
    logic signed [31:0] low_y;
    logic signed [31:0] low_z;
    logic signed [31:0] high_x;
    logic signed [31:0] high_y;
    logic signed [31:0] high_z;
    logic        [30:0] radius;
  } out_t;

endpackage

`default_nettype wire

// ===== design/bounding_volume_transform_unit.sv =====
// ---------------------------------------------------------------------------
// bounding_volume_transform_unit: local bounding volume to world space
// Accumulates matrix columns into world center and extents, emits a sphere
// or an axis-aligned box on the translation column.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+----------------------
//  item    | in        | start && !busy           | item_i   (in_t)
//  result  | out       | done_o, one cycle        | result_o (out_t)
//  config  | in        | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
//  Column 0..2: busy while six products pass through the one shared
//  multiplier, and then while its output register drains.
//  Column 3: busy while the result is formed; the result strobe follows in
//  the next cycle, which is also the first cycle a new item can be taken.
//  Reset clears the config registers, the accumulators and the sequencer.
//  The receiver cannot stall; a result is shown once and dropped.
// ---------------------------------------------------------------------------
`default_nettype none

module bounding_volume_transform_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire bvt_pkg::in_t                       item_i,
  output logic                                    done_o,
  output bvt_pkg::out_t                           result_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [bvt_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [bvt_pkg::CfgDataW-1:0]       cfg_data_i
);

  typedef enum logic [1:0] {
    StIdle,
    StAcc,
    StFin
  } state_e;

  state_e state_q;
  logic [2:0] cnt_q;
  bvt_pkg::in_t item_q;
  logic done_q;
  bvt_pkg::out_t result_q;

  logic        [1:0]  mode_q;
  logic signed [31:0] center_q [3];
  logic        [30:0] rad_q;
  logic        [30:0] half_q   [3];

  logic signed [31:0] csum_q [3];
  logic signed [31:0] esum_q [3];

  // ---- helpers ----
  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v[63:31] == '0 || v[63:31] == '1) begin
      r = v[31:0];
    end else if (v[63]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    logic signed [31:0] r;
    s = {a[31], a} + {b[31], b};
    if (s[32] == s[31]) begin
      r = s[31:0];
    end else if (s[32]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    logic signed [31:0] r;
    s = {a[31], a} - {b[31], b};
    if (s[32] == s[31]) begin
      r = s[31:0];
    end else if (s[32]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

  // ---- operand selection for the shared multiplier ----
  logic [1:0]         row;
  logic signed [31:0] elem;
  logic signed [31:0] elem_v [3];
  logic signed [32:0] elem_abs;
  logic signed [31:0] coef_c;
  logic        [30:0] coef_h;
  logic        [30:0] scale_max;
  logic        [30:0] scale_xy;
  logic               mul_en;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [63:0] mul_res;

  logic [2:0]         acc_step;
  logic [1:0]         acc_row;
  logic signed [31:0] acc_term;

  assign elem_v[0] = item_q.elem_x;
  assign elem_v[1] = item_q.elem_y;
  assign elem_v[2] = item_q.elem_z;

  assign row = cnt_q[2:1];

  always_comb begin
    case (row)
      2'd0:    elem = item_q.elem_x;
      2'd1:    elem = item_q.elem_y;
      default: elem = item_q.elem_z;
    endcase
    case (item_q.column)
      2'd0: begin
        coef_c = center_q[0];
        coef_h = half_q[0];
      end
      2'd1: begin
        coef_c = center_q[1];
        coef_h = half_q[1];
      end
      default: begin
        coef_c = center_q[2];
        coef_h = half_q[2];
      end
    endcase
  end

  assign elem_abs = elem[31] ? -{elem[31], elem} : {elem[31], elem};

  assign scale_xy  = (item_q.scale_x > item_q.scale_y) ? item_q.scale_x : item_q.scale_y;
  assign scale_max = (item_q.scale_z > scale_xy) ? item_q.scale_z : scale_xy;

  always_comb begin
    mul_en = 1'b0;
    mul_a  = {2'b00, rad_q};
    mul_b  = {2'b00, scale_max};
    case (state_q)
      StAcc: begin
        mul_en = (cnt_q < 3'd6);
        // even steps: center term, odd steps: extent term
        if (cnt_q[0]) begin
          mul_a = elem_abs;
          mul_b = {2'b00, coef_h};
        end else begin
          mul_a = {elem[31], elem};
          mul_b = {coef_c[31], coef_c};
        end
      end
      StFin: begin
        mul_en = (cnt_q == 3'd0);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  bvt_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .res_o (mul_res)
  );

  // product of the previous step is read from the multiplier register
  assign acc_step = cnt_q - 3'd1;
  assign acc_row  = acc_step[2:1];
  assign acc_term = sat64(mul_res);

  // ---- world radius clamp ----
  logic [30:0] rad_world;
  assign rad_world = (mul_res[63:31] != '0) ? 31'h7fff_ffff : mul_res[30:0];

  assign busy     = (state_q != StIdle);
  assign done_o   = done_q;
  assign result_o = result_q;

  // ---- sequencer, accumulators and registered result ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      item_q    <= '0;
      done_q    <= 1'b0;
      result_q  <= '0;
      mode_q    <= bvt_pkg::ShapeNone;
      rad_q     <= '0;
      for (int i = 0; i < 3; i++) begin
        center_q[i] <= '0;
        half_q[i]   <= '0;
        csum_q[i]   <= '0;
        esum_q[i]   <= '0;
      end
    end else begin
      // strobe registered from the last cycle of a translation column, sphere or box mode only
      done_q <= (state_q == StFin) && (cnt_q != 3'd0) &&
                ((mode_q == bvt_pkg::ShapeSphere) || (mode_q == bvt_pkg::ShapeBox));

      if (cfg_we_i) begin
        case (cfg_idx_i)
          bvt_pkg::CfgShapeMode: mode_q      <= cfg_data_i[1:0];
          bvt_pkg::CfgCenterX:   center_q[0] <= cfg_data_i;
          bvt_pkg::CfgCenterY:   center_q[1] <= cfg_data_i;
          bvt_pkg::CfgCenterZ:   center_q[2] <= cfg_data_i;
          bvt_pkg::CfgRadius:    rad_q       <= cfg_data_i[30:0];
          bvt_pkg::CfgHalfX:     half_q[0]   <= cfg_data_i[30:0];
          bvt_pkg::CfgHalfY:     half_q[1]   <= cfg_data_i[30:0];
          bvt_pkg::CfgHalfZ:     half_q[2]   <= cfg_data_i[30:0];
          default: ;
        endcase
      end

      case (state_q)
        StIdle: begin
          if (start) begin
            item_q  <= item_i;
            cnt_q   <= '0;
            state_q <= (item_i.column == bvt_pkg::ColTranslate) ? StFin : StAcc;
          end
        end

        StAcc: begin
          if (cnt_q != 3'd0) begin
            if (acc_step[0]) begin
              esum_q[acc_row] <= sat_add(esum_q[acc_row], acc_term);
            end else begin
              csum_q[acc_row] <= sat_add(csum_q[acc_row], acc_term);
            end
          end
          if (cnt_q == 3'd6) begin
            state_q <= StIdle;
          end
          cnt_q <= cnt_q + 3'd1;
        end

        StFin: begin
          if (cnt_q == 3'd0) begin
            // translation is added to the center sums to form the world center
            for (int i = 0; i < 3; i++) begin
              csum_q[i] <= sat_add(csum_q[i], elem_v[i]);
            end
            cnt_q <= 3'd1;
          end else begin
            result_q.shape <= mode_q;
            if (mode_q == bvt_pkg::ShapeSphere) begin
              result_q.low_x  <= csum_q[0];
              result_q.low_y  <= csum_q[1];
              result_q.low_z  <= csum_q[2];
              result_q.high_x <= csum_q[0];
              result_q.high_y <= csum_q[1];
              result_q.high_z <= csum_q[2];
              result_q.radius <= rad_world;
            end else begin
              result_q.low_x  <= sat_sub(csum_q[0], esum_q[0]);
              result_q.low_y  <= sat_sub(csum_q[1], esum_q[1]);
              result_q.low_z  <= sat_sub(csum_q[2], esum_q[2]);
              result_q.high_x <= sat_add(csum_q[0], esum_q[0]);
              result_q.high_y <= sat_add(csum_q[1], esum_q[1]);
              result_q.high_z <= sat_add(csum_q[2], esum_q[2]);
              result_q.radius <= '0;
            end
            for (int i = 0; i < 3; i++) begin
              csum_q[i] <= '0;
              esum_q[i] <= '0;
            end
            state_q <= StIdle;
          end
        end

        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/bvt_mul.sv =====
// ---------------------------------------------------------------------------
// bvt_mul: shared fixed point multiplier
// 33x33 signed product registered, then round-half-up rescale by FracBits.
// ---------------------------------------------------------------------------
`default_nettype none

module bvt_mul (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [32:0] a_i,
  input  wire logic signed [32:0] b_i,
  output logic signed [63:0]      res_o
);

  logic signed [65:0] full;
  logic signed [63:0] prod_q;
  logic signed [63:0] rnd;

  assign full = a_i * b_i;

  // operand magnitudes stay at or below 2^31, so the product fits 64 bits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= full[63:0];
    end
  end

  // floor((p + half) / 2^F) for either sign is an arithmetic shift
  assign rnd   = prod_q + (64'sd1 <<< (bvt_pkg::FracBits - 1));
  assign res_o = rnd >>> bvt_pkg::FracBits;

endmodule

`default_nettype wire

// ===== design/bvt_checker.sv =====
// ---------------------------------------------------------------------------
// bvt_checker: port level checks for the bounding volume transform
// Result timing against the item handshake and result consistency.
// ---------------------------------------------------------------------------
`default_nettype none

module bvt_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          done_o,
  input wire bvt_pkg::out_t result_o
);

  // a result only closes out an item that was in progress
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without a transaction in progress");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("back to back result strobes");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_sphere_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.shape == bvt_pkg::ShapeSphere) |->
      (result_o.low_x == result_o.high_x && result_o.low_y == result_o.high_y &&
       result_o.low_z == result_o.high_z))
    else $error("sphere result with differing low and high");

  a_box_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.shape != bvt_pkg::ShapeSphere) |->
      (result_o.shape == bvt_pkg::ShapeBox && result_o.radius == '0 &&
       result_o.low_x <= result_o.high_x && result_o.low_y <= result_o.high_y &&
       result_o.low_z <= result_o.high_z))
    else $error("bad box result");

endmodule

bind bounding_volume_transform_unit bvt_checker u_bvt_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);

`default_nettype wire
